// ===== hdl/l1_nearest_five_search_macros.svh =====
// Assertion macros for the nearest-five search RTL.
// Needs signals named clock and reset in the including module.
`ifndef L1_NEAREST_FIVE_SEARCH_MACROS_SVH
`define L1_NEAREST_FIVE_SEARCH_MACROS_SVH

// Checked on every edge outside reset.
`define L1NFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define L1NFS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/l1nfs_pkg.sv =====
// Shared types and constants for the nearest-five pose search.
// No dependencies.
`timescale 1ns / 1ps

package l1nfs_pkg;

   // field widths of the transfer payloads
   localparam int ENTRY_IN_W  = 12;
   localparam int JOINT_W     = 4;
   localparam int AXIS_W      = 2;
   localparam int COORD_W     = 16;
   localparam int RANK_W      = 3;
   localparam int ENTRY_OUT_W = 13;
   localparam int DIST_W      = 22;
   localparam int CSR_W       = 13;

   localparam logic [DIST_W-1:0] DIST_MAX      = '1;
   localparam logic [CSR_W-1:0]  ENTRIES_RESET = 13'd4096;

   // default sizes
   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int JOINT_COUNT_DEF = 14;
   localparam int AXIS_COUNT_DEF  = 3;
   localparam int MATCH_COUNT_DEF = 5;

   localparam int CMD_QUEUE_DEPTH = 4;

   // req_kind codes
   localparam logic KIND_POSE  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_POSE,
      OP_QUERY
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type                op;
      logic                      start;
      logic [ENTRY_IN_W-1:0]     entry;
      logic [JOINT_W-1:0]        joint;
      logic [AXIS_W-1:0]         axis;
      logic [COORD_W-1:0]        coord;
   } cmd_type;

endpackage

// ===== hdl/l1nfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module l1nfs_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/l1nfs_front.sv =====
// Front end: checks each incoming item and turns it into a command.
// Depends on l1nfs_pkg.
`timescale 1ns / 1ps

module l1nfs_front import l1nfs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int JOINT_COUNT = JOINT_COUNT_DEF,
   parameter int AXIS_COUNT  = AXIS_COUNT_DEF
) (
   input  logic                  push,
   input  logic                  full,
   input  logic                  req_kind,
   input  logic [ENTRY_IN_W-1:0] req_entry,
   input  logic [JOINT_W-1:0]    req_joint,
   input  logic [AXIS_W-1:0]     req_axis,
   input  logic [COORD_W-1:0]    req_coordinate,
   input  logic                  req_start_search,
   output logic                  cmd_push,
   output cmd_type               cmd
);

   logic slot_ok;
   logic entry_ok;

   assign slot_ok  = (32'(req_joint) < 32'(JOINT_COUNT)) && (32'(req_axis) < 32'(AXIS_COUNT));
   assign entry_ok = 32'(req_entry) < 32'(MAX_ENTRIES);

   always_comb begin
      cmd.entry = req_entry;
      cmd.joint = req_joint;
      cmd.axis  = req_axis;
      cmd.coord = req_coordinate;
      unique case (req_kind)
         KIND_POSE: begin
            cmd.op    = (slot_ok && entry_ok) ? OP_POSE : OP_NONE;
            cmd.start = 1'b0;
         end
         KIND_QUERY: begin
            cmd.op    = slot_ok ? OP_QUERY : OP_NONE;
            cmd.start = req_start_search;
         end
         default: begin
            cmd.op    = OP_NONE;
            cmd.start = 1'b0;
         end
      endcase
   end

   // items with nothing to store and no search to start are dropped here
   assign cmd_push = push && !full && ((cmd.op != OP_NONE) || cmd.start);

endmodule

// ===== hdl/l1nfs_cmd_queue.sv =====
// Short command queue between front end and search engine.
// Depends on l1nfs_pkg.
`timescale 1ns / 1ps

module l1nfs_cmd_queue import l1nfs_pkg::*; #(
   parameter int  DEPTH = CMD_QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    vld,
   output cmd_type head,
   input  logic    pop
);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign vld     = count_ff != '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && vld;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/l1nfs_back.sv =====
// Search engine: stores poses, walks the store, keeps the nearest matches
// and hands them out. Depends on l1nfs_pkg, l1nfs_ram and the macro header.
`timescale 1ns / 1ps
`include "l1_nearest_five_search_macros.svh"

module l1nfs_back import l1nfs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int JOINT_COUNT = JOINT_COUNT_DEF,
   parameter int AXIS_COUNT  = AXIS_COUNT_DEF,
   parameter int MATCH_COUNT = MATCH_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CSR_W-1:0]       entries_in_use,
   input  logic                   cmd_vld,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [RANK_W-1:0]      rsp_rank,
   output logic [ENTRY_OUT_W-1:0] rsp_match_entry,
   output logic [DIST_W-1:0]      rsp_distance,
   output logic                   rsp_last
);

   localparam int POSE  = JOINT_COUNT * AXIS_COUNT;
   localparam int PA_W  = $clog2(MAX_ENTRIES * POSE);
   localparam int QA_W  = (POSE > 1) ? $clog2(POSE) : 1;
   localparam int CW    = ($clog2(MAX_ENTRIES + 1) > CSR_W) ? $clog2(MAX_ENTRIES + 1) : CSR_W;
   localparam int SUM_W = $clog2(POSE * 65535 + 1);
   localparam int FW    = $clog2(MATCH_COUNT + 1);
   localparam int RW    = (MATCH_COUNT > 1) ? $clog2(MATCH_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           n_ff, n_in, e_ff, e_in, n_calc;
   logic [QA_W-1:0]         k_ff, k_in;
   logic [PA_W-1:0]         base_ff, base_in;
   logic                    issue_done_ff, issue_done_in;

   // read stage (tags line up with the RAM read data)
   logic                    rd_vld_ff, rd_first_ff, rd_lastk_ff, rd_laste_ff;
   logic [ENTRY_OUT_W-1:0]  rd_ent_ff;
   // absolute difference stage
   logic                    ab_vld_ff, ab_first_ff, ab_lastk_ff, ab_laste_ff;
   logic [ENTRY_OUT_W-1:0]  ab_ent_ff;
   logic [COORD_W-1:0]      ab_abs_ff, ab_abs_in;
   // accumulation
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic                    cand_vld_ff, cand_vld_in, cand_laste_ff;
   logic [DIST_W-1:0]       cand_dist_ff, cand_dist_in;
   logic [ENTRY_OUT_W-1:0]  cand_ent_ff;

   logic [DIST_W-1:0]       best_dist_ff [MATCH_COUNT];
   logic [DIST_W-1:0]       best_dist_in [MATCH_COUNT];
   logic [ENTRY_OUT_W-1:0]  best_ent_ff  [MATCH_COUNT];
   logic [ENTRY_OUT_W-1:0]  best_ent_in  [MATCH_COUNT];
   logic [FW-1:0]           filled_ff, filled_in, pos;
   logic [RW-1:0]           rank_ff, rank_in;
   logic [MATCH_COUNT-1:0]  le;

   logic                    issue, k_last, e_last;
   logic [31:0]             slot32;
   logic                    pose_wr, query_wr;
   logic [PA_W-1:0]         pose_wr_addr, pose_rd_addr;
   logic [QA_W-1:0]         query_wr_addr;
   logic [COORD_W-1:0]      pose_rd_data, query_rd_data;
   logic signed [COORD_W:0] diff;

   // ---------------- storage ----------------
   assign slot32        = 32'(cmd.joint) * 32'(AXIS_COUNT) + 32'(cmd.axis);
   assign pose_wr       = cmd_pop && (cmd.op == OP_POSE);
   assign query_wr      = cmd_pop && (cmd.op == OP_QUERY);
   assign pose_wr_addr  = PA_W'(32'(cmd.entry) * 32'(POSE) + slot32);
   assign query_wr_addr = QA_W'(slot32);
   assign pose_rd_addr  = base_ff + PA_W'(k_ff);

   l1nfs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ENTRIES * POSE)) u_pose_ram (
      .clock   (clock),
      .wr_en   (pose_wr),
      .wr_addr (pose_wr_addr),
      .wr_data (cmd.coord),
      .rd_addr (pose_rd_addr),
      .rd_data (pose_rd_data)
   );

   l1nfs_ram #(.WIDTH(COORD_W), .DEPTH(POSE)) u_query_ram (
      .clock   (clock),
      .wr_en   (query_wr),
      .wr_addr (query_wr_addr),
      .wr_data (cmd.coord),
      .rd_addr (k_ff),
      .rd_data (query_rd_data)
   );

   // ---------------- control ----------------
   // a start waits for idle; plain loads may also go while results drain
   assign cmd_pop = cmd_vld && ((state_ff == ST_IDLE) ||
                                ((state_ff == ST_EMIT) && !cmd.start));
   assign issue   = (state_ff == ST_SEARCH) && !issue_done_ff;
   assign k_last  = k_ff == QA_W'(POSE - 1);
   assign e_last  = e_ff == (n_ff - CW'(1));
   assign n_calc  = (CW'(entries_in_use) < CW'(MAX_ENTRIES)) ?
                    CW'(entries_in_use) : CW'(MAX_ENTRIES);

   // datapath
   assign diff = $signed({query_rd_data[COORD_W-1], query_rd_data}) -
                 $signed({pose_rd_data[COORD_W-1], pose_rd_data});
   assign ab_abs_in = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

   always_comb begin
      acc_in       = (ab_first_ff ? '0 : acc_ff) + SUM_W'(ab_abs_ff);
      cand_vld_in  = ab_vld_ff && ab_lastk_ff;
      cand_dist_in = (32'(acc_in) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_in);
   end

   // sorted insertion; equal distances keep the earlier entry first
   always_comb begin
      for (int i = 0; i < MATCH_COUNT; i++) begin
         le[i] = (FW'(i) < filled_ff) && (best_dist_ff[i] <= cand_dist_ff);
      end
      pos = FW'($countones(le));
      for (int i = 0; i < MATCH_COUNT; i++) begin
         best_dist_in[i] = best_dist_ff[i];
         best_ent_in[i]  = best_ent_ff[i];
      end
      filled_in = filled_ff;
      if (cand_vld_ff && (pos < FW'(MATCH_COUNT))) begin
         for (int i = 1; i < MATCH_COUNT; i++) begin
            if (FW'(i) > pos) begin
               best_dist_in[i] = best_dist_ff[i-1];
               best_ent_in[i]  = best_ent_ff[i-1];
            end
         end
         for (int i = 0; i < MATCH_COUNT; i++) begin
            if (FW'(i) == pos) begin
               best_dist_in[i] = cand_dist_ff;
               best_ent_in[i]  = cand_ent_ff;
            end
         end
         if (filled_ff < FW'(MATCH_COUNT)) begin
            filled_in = filled_ff + FW'(1);
         end
      end

      state_in      = state_ff;
      n_in          = n_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      base_in       = base_ff;
      issue_done_in = issue_done_ff;
      rank_in       = rank_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.start) begin
               n_in          = n_calc;
               e_in          = '0;
               k_in          = '0;
               base_in       = '0;
               issue_done_in = 1'b0;
               filled_in     = '0;
               // an empty store gives no results at all
               if (n_calc != '0) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (issue) begin
               if (k_last) begin
                  k_in    = '0;
                  e_in    = e_ff + CW'(1);
                  base_in = base_ff + PA_W'(POSE);
                  if (e_last) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  k_in = k_ff + QA_W'(1);
               end
            end
            if (cand_vld_ff && cand_laste_ff) begin
               state_in = ST_EMIT;
               rank_in  = '0;
            end
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rank_in = rank_ff + RW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      e_ff          <= e_in;
      k_ff          <= k_in;
      base_ff       <= base_in;
      issue_done_ff <= issue_done_in;
      rank_ff       <= rank_in;
      filled_ff     <= filled_in;
      rd_first_ff   <= k_ff == '0;
      rd_lastk_ff   <= k_last;
      rd_laste_ff   <= e_last;
      rd_ent_ff     <= ENTRY_OUT_W'(e_ff + CW'(1));
      ab_first_ff   <= rd_first_ff;
      ab_lastk_ff   <= rd_lastk_ff;
      ab_laste_ff   <= rd_laste_ff;
      ab_ent_ff     <= rd_ent_ff;
      ab_abs_ff     <= ab_abs_in;
      if (ab_vld_ff) begin
         acc_ff <= acc_in;
      end
      cand_dist_ff  <= cand_dist_in;
      cand_ent_ff   <= ab_ent_ff;
      cand_laste_ff <= ab_laste_ff;
      for (int i = 0; i < MATCH_COUNT; i++) begin
         best_dist_ff[i] <= best_dist_in[i];
         best_ent_ff[i]  <= best_ent_in[i];
      end
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         ab_vld_ff   <= 1'b0;
         cand_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= issue;
         ab_vld_ff   <= rd_vld_ff;
         cand_vld_ff <= cand_vld_in;
      end
   end

   // ---------------- result port ----------------
   assign rsp_empty       = state_ff != ST_EMIT;
   assign rsp_rank        = RANK_W'(rank_ff);
   assign rsp_match_entry = best_ent_ff[rank_ff];
   assign rsp_distance    = best_dist_ff[rank_ff];
   assign rsp_last        = rank_ff == RW'(filled_ff - FW'(1));

   // ---------------- assertions ----------------
   `L1NFS_ASSERT_RST(a_reset_idle, reset |=> state_ff == ST_IDLE, "state not idle after reset")
   `L1NFS_ASSERT(a_cand_in_search, cand_vld_ff |-> state_ff == ST_SEARCH, "distance outside search")
   `L1NFS_ASSERT(a_no_pop_search, cmd_pop |-> state_ff != ST_SEARCH, "command taken mid search")
   `L1NFS_ASSERT(a_emit_filled, state_ff == ST_EMIT |-> filled_ff != '0, "emitting an empty list")
   `L1NFS_ASSERT(a_sorted_out, (rsp_pop && !rsp_empty && !rsp_last) |=> rsp_distance >= $past(rsp_distance), "results out of order")

endmodule

// ===== hdl/l1_nearest_five_search.sv =====
// L1 nearest-five pose search. Poses of JOINT_COUNT x AXIS_COUNT signed 16-bit
// coordinates are loaded one coordinate per transfer (req_kind 0 = database
// entry req_entry, 1 = query). A query transfer with req_start_search set stores
// its coordinate and then searches entries 0 .. entries_in_use-1 (capped at
// MAX_ENTRIES): each entry's L1 distance to the query (saturated at 22 bits) is
// ranked, and the MATCH_COUNT closest come out in ascending distance, equal
// distances in entry order, with a 1-based entry number; rsp_last marks the
// final one. Loads are taken one per cycle while the command queue is not full.
// A search reads the pose RAM through its single read port, one coordinate per
// cycle, and the results then go out one per pop. A four-deep command queue
// keeps taking transfers while a search runs; loads behind a start are stored
// while results drain, a new start waits until the last result is popped.
// Coordinates never written read as unknown. csr_wr_data is written to
// entries_in_use (reset 4096) whenever csr_wr_en is high; change it only
// while the block is idle.
// Depends on l1nfs_pkg, l1nfs_front, l1nfs_cmd_queue and l1nfs_back.
`timescale 1ns / 1ps

module l1_nearest_five_search import l1nfs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int JOINT_COUNT = JOINT_COUNT_DEF,
   parameter int AXIS_COUNT  = AXIS_COUNT_DEF,
   parameter int MATCH_COUNT = MATCH_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_W-1:0]       csr_wr_data,
   // request side
   input  logic                   push,
   output logic                   full,
   input  logic                   req_kind,
   input  logic [ENTRY_IN_W-1:0]  req_entry,
   input  logic [JOINT_W-1:0]     req_joint,
   input  logic [AXIS_W-1:0]      req_axis,
   input  logic [COORD_W-1:0]     req_coordinate,
   input  logic                   req_start_search,
   // response side
   output logic                   empty,
   input  logic                   pop,
   output logic [RANK_W-1:0]      rsp_rank,
   output logic [ENTRY_OUT_W-1:0] rsp_match_entry,
   output logic [DIST_W-1:0]      rsp_distance,
   output logic                   rsp_last
);

   logic [CSR_W-1:0] entries_ff;
   logic             cmd_push;
   cmd_type          cmd_in;
   logic             cmd_vld;
   cmd_type          cmd_head;
   logic             cmd_pop;

   // entries_in_use register, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   // front: validate joint/axis/entry, drop transfers with no effect
   l1nfs_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .JOINT_COUNT (JOINT_COUNT),
      .AXIS_COUNT  (AXIS_COUNT)
   ) u_front (
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_entry        (req_entry),
      .req_joint        (req_joint),
      .req_axis         (req_axis),
      .req_coordinate   (req_coordinate),
      .req_start_search (req_start_search),
      .cmd_push         (cmd_push),
      .cmd              (cmd_in)
   );

   // decouples the request side from a running search
   l1nfs_cmd_queue #(.DEPTH(CMD_QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (full),
      .vld      (cmd_vld),
      .head     (cmd_head),
      .pop      (cmd_pop)
   );

   // back: pose and query RAMs, distance pipeline, top-N list, result port
   l1nfs_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .JOINT_COUNT (JOINT_COUNT),
      .AXIS_COUNT  (AXIS_COUNT),
      .MATCH_COUNT (MATCH_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .entries_in_use  (entries_ff),
      .cmd_vld         (cmd_vld),
      .cmd             (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_rank        (rsp_rank),
      .rsp_match_entry (rsp_match_entry),
      .rsp_distance    (rsp_distance),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/sv/nearest_match_checker.sv =====
// Checker for the nearest-five pose search: watches the load, query, register
// and match channels, predicts each search and compares every match transfer.
// Depends on l1nfs_pkg.
`timescale 1ns / 1ps

module nearest_match_checker import l1nfs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int JOINT_COUNT = JOINT_COUNT_DEF,
   parameter int AXIS_COUNT  = AXIS_COUNT_DEF,
   parameter int MATCH_COUNT = MATCH_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_W-1:0]       csr_wr_data,
   input  logic                   push,
   input  logic                   full,
   input  logic                   req_kind,
   input  logic [ENTRY_IN_W-1:0]  req_entry,
   input  logic [JOINT_W-1:0]     req_joint,
   input  logic [AXIS_W-1:0]      req_axis,
   input  logic [COORD_W-1:0]     req_coordinate,
   input  logic                   req_start_search,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [RANK_W-1:0]      rsp_rank,
   input  logic [ENTRY_OUT_W-1:0] rsp_match_entry,
   input  logic [DIST_W-1:0]      rsp_distance,
   input  logic                   rsp_last,
   output int                     mismatches,
   output int                     matches_waiting,
   output int                     searches_run,
   output int                     matches_checked
);

   localparam int POSE_SIZE  = JOINT_COUNT * AXIS_COUNT;
   localparam int PRINT_CAP  = 40;

   typedef struct {
      logic [RANK_W-1:0]      rank;
      logic [ENTRY_OUT_W-1:0] match_entry;
      logic [DIST_W-1:0]      distance;
      logic                   last;
   } match_type;

   logic signed [COORD_W-1:0] pose_mem  [0:MAX_ENTRIES*POSE_SIZE-1];
   logic signed [COORD_W-1:0] query_mem [0:POSE_SIZE-1];
   int unsigned               entries_cfg;
   match_type                 expected_matches [$];
   int                        lines_printed;

   task automatic report_mismatch(input string msg);
      if (lines_printed < PRINT_CAP) begin
         $display("[%0t] match check: %s", $realtime, msg);
         lines_printed++;
      end
      mismatches++;
   endtask

   // L1 distance of one stored pose to the query, clipped to the 22-bit range
   function automatic int unsigned l1_to_query(input int unsigned pose);
      int unsigned sum;
      int          diff;
      int          k;
      sum = 0;
      for (k = 0; k < POSE_SIZE; k++) begin
         diff = int'(query_mem[k]) - int'(pose_mem[pose*POSE_SIZE + k]);
         sum += (diff < 0) ? -diff : diff;
      end
      return (sum > 32'(DIST_MAX)) ? 32'(DIST_MAX) : sum;
   endfunction

   // top-N by sorted insertion; equal distances keep the lower entry first
   task automatic predict_nearest_matches();
      int unsigned n;
      int unsigned cand_dist;
      int unsigned filled;
      int unsigned pos;
      int unsigned pose;
      int unsigned k;
      int unsigned best_dist  [MATCH_COUNT];
      int unsigned best_entry [MATCH_COUNT];
      match_type   m;
      n = (entries_cfg > MAX_ENTRIES) ? MAX_ENTRIES : entries_cfg;
      filled = 0;
      for (k = 0; k < MATCH_COUNT; k++) begin
         best_dist[k]  = 32'(DIST_MAX);
         best_entry[k] = 0;
      end
      for (pose = 0; pose < n; pose++) begin
         cand_dist = l1_to_query(pose);
         if (!(filled == MATCH_COUNT && cand_dist >= best_dist[MATCH_COUNT-1])) begin
            pos = 0;
            while (pos < filled && best_dist[pos] <= cand_dist)
               pos++;
            if (filled < MATCH_COUNT)
               filled++;
            for (k = filled - 1; k > pos; k--) begin
               best_dist[k]  = best_dist[k-1];
               best_entry[k] = best_entry[k-1];
            end
            best_dist[pos]  = cand_dist;
            best_entry[pos] = pose + 1;
         end
      end
      for (k = 0; k < filled; k++) begin
         m.rank        = k[RANK_W-1:0];
         m.match_entry = best_entry[k][ENTRY_OUT_W-1:0];
         m.distance    = best_dist[k][DIST_W-1:0];
         m.last        = (k + 1 == filled);
         expected_matches.insert(expected_matches.size(), m);
      end
      searches_run++;
   endtask

   task automatic apply_request();
      logic        slot_ok;
      int unsigned slot;
      slot_ok = (req_joint < JOINT_COUNT) && (req_axis < AXIS_COUNT);
      slot    = req_joint * AXIS_COUNT + req_axis;
      if (req_kind == KIND_POSE) begin
         if (slot_ok && req_entry < MAX_ENTRIES)
            pose_mem[req_entry*POSE_SIZE + slot] = req_coordinate;
      end else begin
         if (slot_ok)
            query_mem[slot] = req_coordinate;
         if (req_start_search)
            predict_nearest_matches();
      end
   endtask

   task automatic check_match();
      match_type want;
      if (expected_matches.size() == 0) begin
         report_mismatch($sformatf("unexpected match rank %0d entry %0d distance %0d last %0d",
                                   rsp_rank, rsp_match_entry, rsp_distance, rsp_last));
         return;
      end
      want = expected_matches.pop_front();
      matches_checked++;
      if (rsp_rank !== want.rank || rsp_match_entry !== want.match_entry ||
          rsp_distance !== want.distance || rsp_last !== want.last)
         report_mismatch($sformatf({"got rank %0d entry %0d distance %0d last %0d, ",
                                    "want rank %0d entry %0d distance %0d last %0d"},
                                   rsp_rank, rsp_match_entry, rsp_distance, rsp_last,
                                   want.rank, want.match_entry, want.distance, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entries_cfg = 32'(ENTRIES_RESET);
         expected_matches.delete();
         mismatches      = 0;
         searches_run    = 0;
         matches_checked = 0;
         lines_printed   = 0;
      end else begin
         if (pop && !empty)
            check_match();
         if (csr_wr_en)
            entries_cfg = 32'(csr_wr_data);
         if (push && !full)
            apply_request();
      end
      matches_waiting <= expected_matches.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the nearest-five pose search: makes load, query and
// register traffic, stalls the match side and gives the verdict.
// Depends on l1nfs_pkg, l1_nearest_five_search and nearest_match_checker.
`timescale 1ns / 1ps

module tb_top;
   import l1nfs_pkg::*;

   localparam int POSE_SIZE     = JOINT_COUNT_DEF * AXIS_COUNT_DEF;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_ITEMS  = 30;
   localparam int SMALL_SET_MAX = 6;
   localparam int HOLD_AFTER    = 3;    // matches drained before the long stall
   localparam int HOLD_CYCLES   = 600;
   // longest quiet stretch is a small-store search under the long stall
   localparam int IDLE_LIMIT    = 8 * (SMALL_SET_MAX * POSE_SIZE + HOLD_CYCLES);

   typedef enum {DRAIN_ALWAYS, DRAIN_HALF, DRAIN_SPARSE, DRAIN_MOSTLY} drain_mode_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_W-1:0]       csr_wr_data      = '0;
   logic                   push             = 1'b0;
   logic                   full;
   logic                   req_kind         = KIND_POSE;
   logic [ENTRY_IN_W-1:0]  req_entry        = '0;
   logic [JOINT_W-1:0]     req_joint        = '0;
   logic [AXIS_W-1:0]      req_axis         = '0;
   logic [COORD_W-1:0]     req_coordinate   = '0;
   logic                   req_start_search = 1'b0;
   logic                   empty;
   logic                   pop              = 1'b0;
   logic [RANK_W-1:0]      rsp_rank;
   logic [ENTRY_OUT_W-1:0] rsp_match_entry;
   logic [DIST_W-1:0]      rsp_distance;
   logic                   rsp_last;

   int mismatches;
   int matches_waiting;
   int searches_run;
   int matches_checked;

   int burst_left     = 0;
   int entries_loaded = 0;   // poses 0 .. entries_loaded-1 hold all coordinates
   int random_items   = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;

   l1_nearest_five_search dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_entry        (req_entry),
      .req_joint        (req_joint),
      .req_axis         (req_axis),
      .req_coordinate   (req_coordinate),
      .req_start_search (req_start_search),
      .empty            (empty),
      .pop              (pop),
      .rsp_rank         (rsp_rank),
      .rsp_match_entry  (rsp_match_entry),
      .rsp_distance     (rsp_distance),
      .rsp_last         (rsp_last)
   );

   nearest_match_checker match_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_entry        (req_entry),
      .req_joint        (req_joint),
      .req_axis         (req_axis),
      .req_coordinate   (req_coordinate),
      .req_start_search (req_start_search),
      .empty            (empty),
      .pop              (pop),
      .rsp_rank         (rsp_rank),
      .rsp_match_entry  (rsp_match_entry),
      .rsp_distance     (rsp_distance),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .matches_waiting  (matches_waiting),
      .searches_run     (searches_run),
      .matches_checked  (matches_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: any transfer on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Match side: pop on a randomly chosen pattern that changes after a random span,
   // plus one long stall so the block backs up and raises full on the input side.
   initial begin : match_drain
      drain_mode_type mode;
      int             span;
      int             popped;
      bit             long_hold_done;
      mode           = DRAIN_ALWAYS;
      span           = 0;
      popped         = 0;
      long_hold_done = 0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty)
            popped++;
         if (!long_hold_done && popped >= HOLD_AFTER) begin
            long_hold_done = 1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = drain_mode_type'($urandom_range(3));
               span = $urandom_range(200, 20);
            end
            span--;
            case (mode)
               DRAIN_ALWAYS: pop <= 1'b1;
               DRAIN_HALF:   pop <= ($urandom_range(1) == 0);
               DRAIN_SPARSE: pop <= ($urandom_range(3) == 0);
               default:      pop <= ($urandom_range(7) != 0);
            endcase
         end
      end
   end

   // Mix of wide, near-zero (to provoke equal distances), extreme and
   // mid-range coordinates.
   function automatic logic [COORD_W-1:0] pick_coord(input bit near_zero);
      int v;
      if (near_zero) begin
         v = int'($urandom_range(4)) - 2;
      end else begin
         case ($urandom_range(9))
            0, 1, 2: v = int'($urandom_range(65535));
            3, 4:    v = int'($urandom_range(4)) - 2;
            5: begin
               case ($urandom_range(3))
                  0:       v = -32768;
                  1:       v = 32767;
                  2:       v = 0;
                  default: v = -1;
               endcase
            end
            default: v = int'($urandom_range(600)) - 300;
         endcase
      end
      return v[COORD_W-1:0];
   endfunction

   // One transfer on the input side. Transfers go out in bursts; push only
   // drops in the gap between bursts, so back-to-back items keep it high.
   task automatic send_coord(input logic kind, input int entry, input int joint,
                             input int axis, input logic [COORD_W-1:0] coord,
                             input logic start);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(99) < 35) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(32, 1);
      end
      burst_left--;
      push             <= 1'b1;
      req_kind         <= kind;
      req_entry        <= entry[ENTRY_IN_W-1:0];
      req_joint        <= joint[JOINT_W-1:0];
      req_axis         <= axis[AXIS_W-1:0];
      req_coordinate   <= coord;
      req_start_search <= start;
      do @(posedge clock); while (full);
   endtask

   // Stop offering and wait until every predicted match has been popped,
   // then give the back end time to store loads queued behind the last start.
   task automatic wait_for_matches();
      push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (matches_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entries_in_use(input int n);
      wait_for_matches();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n[CSR_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic load_pose(input int entry, input bit near_zero);
      for (int j = 0; j < JOINT_COUNT_DEF; j++)
         for (int a = 0; a < AXIS_COUNT_DEF; a++)
            send_coord(KIND_POSE, entry, j, a, pick_coord(near_zero), 1'b0);
   endtask

   task automatic load_const_pose(input int entry, input logic [COORD_W-1:0] value);
      for (int j = 0; j < JOINT_COUNT_DEF; j++)
         for (int a = 0; a < AXIS_COUNT_DEF; a++)
            send_coord(KIND_POSE, entry, j, a, value, 1'b0);
   endtask

   // whole query at one value; the final coordinate starts the search
   task automatic load_const_query(input logic [COORD_W-1:0] value);
      for (int j = 0; j < JOINT_COUNT_DEF; j++)
         for (int a = 0; a < AXIS_COUNT_DEF; a++)
            send_coord(KIND_QUERY, 0, j, a, value,
                       (j == JOINT_COUNT_DEF - 1) && (a == AXIS_COUNT_DEF - 1));
   endtask

   // Every pose a search will read must be written in full first.
   task automatic ensure_loaded(input int n);
      while (entries_loaded < n) begin
         load_pose(entries_loaded, 1'($urandom_range(1)));
         entries_loaded++;
      end
   endtask

   // Well-formed search: a few pose edits, a few query edits, then a start.
   // Starts on pose loads are legal and ignored by the block.
   task automatic run_search_sequence(input int n);
      int entry;
      repeat ($urandom_range(6)) begin
         entry = ($urandom_range(7) == 0) ? $urandom_range(MAX_ENTRIES_DEF - 1)
                                          : $urandom_range(n - 1);
         send_coord(KIND_POSE, entry, $urandom_range(JOINT_COUNT_DEF - 1),
                    $urandom_range(AXIS_COUNT_DEF - 1), pick_coord(0),
                    1'($urandom_range(1)));
         random_items++;
      end
      repeat ($urandom_range(4)) begin
         send_coord(KIND_QUERY, $urandom_range(MAX_ENTRIES_DEF - 1),
                    $urandom_range(JOINT_COUNT_DEF - 1), $urandom_range(AXIS_COUNT_DEF - 1),
                    pick_coord(0), 1'b0);
         random_items++;
      end
      // now and then the start sits on a slot the block does not store
      if ($urandom_range(9) == 0)
         send_coord(KIND_QUERY, $urandom_range(MAX_ENTRIES_DEF - 1),
                    $urandom_range(2 ** JOINT_W - 1, JOINT_COUNT_DEF),
                    $urandom_range(2 ** AXIS_W - 1), pick_coord(0), 1'b1);
      else
         send_coord(KIND_QUERY, $urandom_range(MAX_ENTRIES_DEF - 1),
                    $urandom_range(JOINT_COUNT_DEF - 1), $urandom_range(AXIS_COUNT_DEF - 1),
                    pick_coord(0), 1'b1);
      random_items++;
   endtask

   // Noise and broken sequences: ignored slots, or query edits without a start.
   task automatic send_noise();
      case ($urandom_range(3))
         0: send_coord(KIND_POSE, $urandom_range(MAX_ENTRIES_DEF - 1),
                       $urandom_range(2 ** JOINT_W - 1, JOINT_COUNT_DEF),
                       $urandom_range(2 ** AXIS_W - 1), pick_coord(0),
                       1'($urandom_range(1)));
         1: send_coord(KIND_POSE, $urandom_range(MAX_ENTRIES_DEF - 1),
                       $urandom_range(2 ** JOINT_W - 1), 2 ** AXIS_W - 1,
                       pick_coord(0), 1'($urandom_range(1)));
         2: send_coord(KIND_QUERY, $urandom_range(MAX_ENTRIES_DEF - 1),
                       $urandom_range(2 ** JOINT_W - 1, JOINT_COUNT_DEF),
                       $urandom_range(2 ** AXIS_W - 1), pick_coord(0), 1'b0);
         default: begin
            repeat ($urandom_range(3, 1))
               send_coord(KIND_QUERY, 0, $urandom_range(JOINT_COUNT_DEF - 1),
                          $urandom_range(AXIS_COUNT_DEF - 1), pick_coord(1), 1'b0);
         end
      endcase
   endtask

   initial begin : stimulus
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: poses at the coordinate extremes, two equal poses for a
      // tie, and a query at the top of the range, which gives the largest
      // possible distance against the all-minimum pose.
      set_entries_in_use(MATCH_COUNT_DEF);
      load_const_pose(0, 16'h8000);
      load_const_pose(1, 16'h0000);
      load_const_pose(2, 16'h0000);
      load_const_pose(3, 16'h0001);
      load_const_pose(4, 16'h7fff);
      entries_loaded = MATCH_COUNT_DEF;
      load_const_query(16'h7fff);
      // top entry number, all entry bits high; never searched at this size
      send_coord(KIND_POSE, MAX_ENTRIES_DEF - 1, JOINT_COUNT_DEF - 1, AXIS_COUNT_DEF - 1,
                 16'hffff, 1'b0);
      // start flag on a pose load is ignored, the coordinate is stored
      send_coord(KIND_POSE, 3, 0, 0, 16'h0005, 1'b1);
      // joint or axis out of range: nothing stored
      send_coord(KIND_POSE, 2, 2 ** JOINT_W - 1, 2 ** AXIS_W - 1, 16'h0064, 1'b0);
      send_coord(KIND_POSE, 1, JOINT_COUNT_DEF, 0, 16'h1234, 1'b0);
      send_coord(KIND_POSE, 1, 0, 2 ** AXIS_W - 1, 16'h4321, 1'b0);
      send_coord(KIND_QUERY, 0, JOINT_COUNT_DEF, 1, 16'h0007, 1'b0);
      // a start on an unstored query slot still searches
      send_coord(KIND_QUERY, 0, 2 ** JOINT_W - 1, 2 ** AXIS_W - 1, 16'h0000, 1'b1);
      send_coord(KIND_QUERY, 0, 0, 0, 16'h8000, 1'b0);
      send_coord(KIND_QUERY, 0, JOINT_COUNT_DEF - 1, AXIS_COUNT_DEF - 1, 16'h0000, 1'b1);
      send_coord(KIND_POSE, 0, 6, 1, 16'h7fff, 1'b0);
      send_coord(KIND_QUERY, 0, 6, 1, 16'h7fff, 1'b1);

      // Random phases at small store sizes; the register is only written
      // once the block has gone idle.
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(3))
            0:       n = MATCH_COUNT_DEF;
            1:       n = SMALL_SET_MAX;
            default: n = $urandom_range(SMALL_SET_MAX, MATCH_COUNT_DEF);
         endcase
         set_entries_in_use(n);
         ensure_loaded(n);
         repeat ($urandom_range(6, 3)) begin
            if ($urandom_range(4) == 0)
               send_noise();
            run_search_sequence(n);
         end
      end
      wait_for_matches();

      $display("Covered %0d searches, %0d match transfers checked, %0d random transfers,",
               searches_run, matches_checked, random_items);
      $display("over %0d store-size settings from %0d to %0d poses, with one long match stall.",
               settings_used, MATCH_COUNT_DEF, SMALL_SET_MAX);
      if (mismatches == 0 && matches_waiting == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
